### src/sorted_delay_list_assert.svh
// Assertion macros for the sorted delay list checker.
// Depends on nothing; taken in by the checker with a plain include.
`ifndef SORTED_DELAY_LIST_ASSERT_SVH
`define SORTED_DELAY_LIST_ASSERT_SVH

// Same-cycle implication, disabled while reset is held
`define SDL_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define SDL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/sdl_pkg.sv
// Shared types and constants for the sorted delay list.
// No dependencies; used by the RAM, the top level and the checker by scoped names.
package sdl_pkg;

    // Defaults for the top-level parameters
    localparam int NODES_DEF    = 16;
    localparam int KEY_BITS_DEF = 32;

    // Port field widths
    localparam int FUNC_W  = 2;
    localparam int NODE_W  = 4;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;
    localparam int ERR_W   = 2;

    // Operation codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_SORTED = 2'd0,
        FUNC_APPEND = 2'd1,
        FUNC_REMOVE = 2'd2
    } t_func;

    // Error codes
    typedef enum logic [ERR_W-1:0] {
        ERR_NONE     = 2'd0,
        ERR_LINKED   = 2'd1,
        ERR_UNLINKED = 2'd2
    } t_err;

endpackage

### src/sdl_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies beyond the package defaults.
module sdl_ram #(
    parameter int WIDTH = sdl_pkg::KEY_BITS_DEF,
    parameter int DEPTH = sdl_pkg::NODES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/sorted_delay_list.sv
// Channel   | Direction | Handshake            | Payload
// command   | in        | start / busy         | i_func, i_node, i_value
// result    | out       | o_valid (one cycle)  | o_count, o_head_node, o_head_value,
//           |           |                      | o_empty_res, o_error
//
// A flagged or ignored command strobes its result 2 cycles after accept, an append 4,
// a remove 3, or 4 when the head goes and the new head key has to be read.
// A sorted insert takes 4 plus one cycle per node compared, up to NODES + 3, set by
// the walk loop reading one key and one link per cycle from the node RAMs.
// Reset (synchronous, active low) empties the list at once; no clearing pass.
// busy stays high from accept until the result is loaded; results cannot be stalled.
//
// Top level of the sorted delay list: sequencer, link flags and three node RAMs.
// Depends on sdl_pkg and sdl_ram.
module sorted_delay_list #(
    parameter int NODES    = sdl_pkg::NODES_DEF,
    parameter int KEY_BITS = sdl_pkg::KEY_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [sdl_pkg::FUNC_W-1:0]  i_func,
    input  logic [sdl_pkg::NODE_W-1:0]  i_node,
    input  logic [sdl_pkg::VALUE_W-1:0] i_value,
    output logic                       o_valid,
    output logic [sdl_pkg::COUNT_W-1:0] o_count,
    output logic [sdl_pkg::NODE_W-1:0]  o_head_node,
    output logic [sdl_pkg::VALUE_W-1:0] o_head_value,
    output logic                       o_empty_res,
    output logic [sdl_pkg::ERR_W-1:0]   o_error
);

    // Link width holds the end marker; address width indexes a slot
    localparam int NW = $clog2(NODES + 1);
    localparam int IW = $clog2(NODES);
    localparam int CW = (NW > sdl_pkg::NODE_W) ? NW : sdl_pkg::NODE_W;
    localparam logic [NW-1:0] END_MARK = NW'(NODES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_WALK,
        S_RM_RD,
        S_RM_KEY,
        S_LINK1,
        S_LINK2,
        S_DONE
    } t_state;

    t_state                      r_state;
    logic [sdl_pkg::FUNC_W-1:0]  r_func;
    logic                        r_node_ok;
    logic [IW-1:0]               r_idx;
    logic [KEY_BITS-1:0]         r_key;
    sdl_pkg::t_err               r_err;
    logic [NW-1:0]               r_at;
    logic [NW-1:0]               r_after;
    logic [NW-1:0]               r_first;
    logic [NW-1:0]               r_last;
    logic [NW-1:0]               r_count;
    logic [KEY_BITS-1:0]         r_head_key;
    logic [NODES-1:0]            r_linked;

    logic                        r_o_valid;
    logic [sdl_pkg::COUNT_W-1:0] r_o_count;
    logic [sdl_pkg::NODE_W-1:0]  r_o_head_node;
    logic [sdl_pkg::VALUE_W-1:0] r_o_head_value;
    logic                        r_o_empty;
    sdl_pkg::t_err               r_o_error;

    // RAM ports
    logic                next_we,  prev_we,  key_we;
    logic [IW-1:0]       next_wa,  prev_wa,  key_wa;
    logic [NW-1:0]       next_wd,  prev_wd;
    logic [IW-1:0]       next_ra,  prev_ra,  key_ra;
    logic [NW-1:0]       next_rd,  prev_rd;
    logic [KEY_BITS-1:0] key_rd;

    logic [CW-1:0]       node_x;
    logic                func_ok;

    assign node_x  = CW'(i_node);
    assign func_ok = (i_func == sdl_pkg::FUNC_SORTED) || (i_func == sdl_pkg::FUNC_APPEND)
                  || (i_func == sdl_pkg::FUNC_REMOVE);

    // Steer RAM reads: walk follows the fresh link, remove reads the slot itself
    always_comb begin
        next_ra = r_first[IW-1:0];
        key_ra  = r_first[IW-1:0];
        prev_ra = r_idx;
        unique case (r_state)
            S_START: begin
                if (r_func == sdl_pkg::FUNC_REMOVE) begin
                    next_ra = r_idx;
                end
            end
            S_WALK, S_RM_RD: begin
                next_ra = next_rd[IW-1:0];
                key_ra  = next_rd[IW-1:0];
            end
            default: begin
                next_ra = r_first[IW-1:0];
            end
        endcase
    end

    // Steer RAM writes: link the new slot, then its neighbours; unlink on remove
    always_comb begin
        next_we = 1'b0;
        prev_we = 1'b0;
        key_we  = 1'b0;
        next_wa = r_idx;
        prev_wa = r_idx;
        key_wa  = r_idx;
        next_wd = r_after;
        prev_wd = r_at;
        unique case (r_state)
            S_LINK1: begin
                next_we = 1'b1;
                prev_we = 1'b1;
                key_we  = 1'b1;
            end
            S_LINK2: begin
                next_we = (r_at != END_MARK);
                next_wa = r_at[IW-1:0];
                next_wd = NW'(r_idx);
                prev_we = (r_after != END_MARK);
                prev_wa = r_after[IW-1:0];
                prev_wd = NW'(r_idx);
            end
            S_RM_RD: begin
                next_we = (prev_rd != END_MARK);
                next_wa = prev_rd[IW-1:0];
                next_wd = next_rd;
                prev_we = (next_rd != END_MARK);
                prev_wa = next_rd[IW-1:0];
                prev_wd = prev_rd;
            end
            default: begin
                next_we = 1'b0;
            end
        endcase
    end

    // Sequencer: state, list registers and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_first   <= END_MARK;
            r_last    <= END_MARK;
            r_count   <= '0;
            r_linked  <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    // Take the transaction
                    if (start) begin
                        r_func    <= i_func;
                        r_node_ok <= func_ok && (node_x < CW'(NODES));
                        r_idx     <= node_x[IW-1:0];
                        r_key     <= KEY_BITS'(i_value);
                        r_err     <= sdl_pkg::ERR_NONE;
                        r_state   <= S_START;
                    end
                end
                S_START: begin
                    if (!r_node_ok) begin
                        r_state <= S_DONE;
                    end else if (r_func == sdl_pkg::FUNC_REMOVE) begin
                        if (!r_linked[r_idx]) begin
                            r_err   <= sdl_pkg::ERR_UNLINKED;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_RM_RD;
                        end
                    end else if (r_linked[r_idx]) begin
                        r_err   <= sdl_pkg::ERR_LINKED;
                        r_state <= S_DONE;
                    end else if ((r_func == sdl_pkg::FUNC_APPEND) || (r_key == '1)) begin
                        // Straight to the tail
                        r_at    <= r_last;
                        r_after <= END_MARK;
                        r_state <= S_LINK1;
                    end else begin
                        // Walk from the head
                        r_at    <= END_MARK;
                        r_after <= r_first;
                        r_state <= (r_first == END_MARK) ? S_LINK1 : S_WALK;
                    end
                end
                S_WALK: begin
                    // Stop before the first larger key, else advance one link
                    if (key_rd > r_key) begin
                        r_state <= S_LINK1;
                    end else begin
                        r_at    <= r_after;
                        r_after <= next_rd;
                        if (next_rd == END_MARK) begin
                            r_state <= S_LINK1;
                        end
                    end
                end
                S_RM_RD: begin
                    // Unlink: end-marker neighbours update first and last
                    if (next_rd == END_MARK) begin
                        r_last <= prev_rd;
                    end
                    r_linked[r_idx] <= 1'b0;
                    r_count         <= r_count - NW'(1);
                    if (prev_rd == END_MARK) begin
                        r_first <= next_rd;
                        r_state <= (next_rd == END_MARK) ? S_DONE : S_RM_KEY;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_RM_KEY: begin
                    r_head_key <= key_rd;
                    r_state    <= S_DONE;
                end
                S_LINK1: begin
                    r_state <= S_LINK2;
                end
                S_LINK2: begin
                    if (r_after == END_MARK) begin
                        r_last <= NW'(r_idx);
                    end
                    if (r_at == END_MARK) begin
                        r_first    <= NW'(r_idx);
                        r_head_key <= r_key;
                    end
                    r_linked[r_idx] <= 1'b1;
                    r_count         <= r_count + NW'(1);
                    r_state         <= S_DONE;
                end
                S_DONE: begin
                    // Load the result for one cycle
                    r_o_valid <= 1'b1;
                    r_o_count <= sdl_pkg::COUNT_W'(r_count);
                    r_o_error <= r_err;
                    if ((r_count == '0) || (r_first == END_MARK)) begin
                        r_o_head_node  <= '0;
                        r_o_head_value <= '0;
                        r_o_empty      <= 1'b1;
                    end else begin
                        r_o_head_node  <= sdl_pkg::NODE_W'(r_first);
                        r_o_head_value <= sdl_pkg::VALUE_W'(r_head_key);
                        r_o_empty      <= 1'b0;
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    sdl_ram #(.WIDTH(NW), .DEPTH(NODES)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (next_we),
        .i_waddr (next_wa),
        .i_wdata (next_wd),
        .i_raddr (next_ra),
        .o_rdata (next_rd)
    );

    sdl_ram #(.WIDTH(NW), .DEPTH(NODES)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (prev_we),
        .i_waddr (prev_wa),
        .i_wdata (prev_wd),
        .i_raddr (prev_ra),
        .o_rdata (prev_rd)
    );

    sdl_ram #(.WIDTH(KEY_BITS), .DEPTH(NODES)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_wa),
        .i_wdata (r_key),
        .i_raddr (key_ra),
        .o_rdata (key_rd)
    );

    assign busy         = (r_state != S_IDLE);
    assign o_valid      = r_o_valid;
    assign o_count      = r_o_count;
    assign o_head_node  = r_o_head_node;
    assign o_head_value = r_o_head_value;
    assign o_empty_res  = r_o_empty;
    assign o_error      = r_o_error;

endmodule

### src/sdl_chk.sv
// Port-level checker for the sorted delay list, bound to the top level.
// Depends on sdl_pkg and sorted_delay_list_assert.svh.
`include "sorted_delay_list_assert.svh"

module sdl_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_valid,
    input logic [sdl_pkg::COUNT_W-1:0] o_count,
    input logic                        o_empty_res,
    input logic [sdl_pkg::ERR_W-1:0]   o_error
);

    logic empty_ok;
    logic error_ok;

    // Empty flag agrees with the count; error code is a defined one
    assign empty_ok = (o_empty_res == (o_count == '0));
    assign error_ok = (o_error == sdl_pkg::ERR_NONE) || (o_error == sdl_pkg::ERR_LINKED)
                   || (o_error == sdl_pkg::ERR_UNLINKED);

    // An accepted transaction holds the block busy in the next cycle
    `SDL_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "no busy after accept")

    // A result only follows work in progress
    `SDL_ASSERT_NOW(a_result_after_work, i_clk, i_rst_n, o_valid, $past(busy), "stray result")

    // The block is ready again while the result is shown
    `SDL_ASSERT_NOW(a_result_ready, i_clk, i_rst_n, o_valid, !busy, "busy while result shown")

    // Empty flag agrees with the count
    `SDL_ASSERT_NOW(a_empty_count, i_clk, i_rst_n, o_valid, empty_ok, "empty flag mismatch")

    // Error code is a defined one
    `SDL_ASSERT_NOW(a_error_code, i_clk, i_rst_n, o_valid, error_ok, "undefined error code")

endmodule

bind sorted_delay_list sdl_chk u_sdl_chk (.*);
